@@ src/i4dq_pkg.sv @@
`default_nettype none

package i4dq_pkg;

    localparam int ACT_W    = 16;
    localparam int SCALE_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int ZERO_W   = 8;
    localparam int NIBBLE_W = 4;
    localparam int DIFF_W   = ZERO_W + 1;
    localparam int DQ_W     = SCALE_W + DIFF_W;
    localparam int PROD_W   = ACT_W + DQ_W;
    localparam int DEQ_W    = 16;
    localparam int VALUE_W  = 48;

    localparam logic [NIBBLE_W-1:0] NIBBLE_MASK  = 4'hf;
    localparam int                  NIBBLE_SHIFT = 4;

    localparam logic MODE_DOT     = 1'b0;
    localparam logic MODE_DEQUANT = 1'b1;

    typedef struct packed {
        logic signed [ACT_W-1:0]   act_low;
        logic signed [ACT_W-1:0]   act_high;
        logic        [BYTE_W-1:0]  packed_byte;
        logic signed [SCALE_W-1:0] group_scale;
        logic        [ZERO_W-1:0]  group_zero;
        logic                      vector_last;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      run_last;
        logic                      vector_end;
    } out_word_t;

    typedef struct packed {
        logic dq_en;
        logic mul_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic add_en;
        logic use_hi;
        logic clear;
    } acc_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_MUL,
        ST_ADD_LO,
        ST_ADD_HI,
        ST_EMIT_DOT,
        ST_EMIT_LO,
        ST_EMIT_HI
    } state_t;

endpackage

`default_nettype wire

@@ src/int4_group_dequant_dot_top.sv @@
// int4 group dequantizer and dot product engine
//
// item channel: one word per packed weight byte, with its group scale, zero
// point and the two activations for the low and high nibble. result channel:
// value with run_last and vector_end. cfg_we/cfg_data write output_mode.
//
// one item is in flight at a time. after acceptance the two nibble lanes form
// scale*(w-zero) in the DEQ step and act*dq in the MUL step; the shared
// accumulator then takes the low and the high product in separate ADD_LO and
// ADD_HI steps, since each add saturates on its own. on a vector's last item an
// EMIT_DOT step follows and loads the dot result; in dequant mode the adds are
// skipped and EMIT_LO and EMIT_HI load the two dequantized words in turn.
//
// the result register lets the next item be accepted while a result waits.
// if the receiver stalls, the block holds in its emit step until the result
// register frees up; no word is dropped.
//
// reset clears the accumulator, output_mode and all handshake state.
`default_nettype none

module int4_group_dequant_dot_top
    import i4dq_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire in_word_t  item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_word_t      result,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data
);

    state_t    state_reg;
    state_t    state_next;
    in_word_t  item_reg;
    logic      mode_reg;
    logic      result_valid_reg;
    logic      result_valid_next;
    out_word_t result_reg;
    out_word_t result_next;
    logic      load;
    logic      out_free;

    lane_ctrl_t lane_ctrl;
    acc_ctrl_t  acc_ctrl;

    logic signed [PROD_W-1:0]  prod_lo;
    logic signed [PROD_W-1:0]  prod_hi;
    logic signed [DEQ_W-1:0]   deq_lo;
    logic signed [DEQ_W-1:0]   deq_hi;
    logic signed [VALUE_W-1:0] acc_value;

    i4dq_lane u_lane_lo
    (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .nibble (item_reg.packed_byte[NIBBLE_W-1:0]),
        .zero   (item_reg.group_zero),
        .scale  (item_reg.group_scale),
        .act    (item_reg.act_low),
        .prod   (prod_lo),
        .deq    (deq_lo)
    );

    i4dq_lane u_lane_hi
    (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .nibble (item_reg.packed_byte[NIBBLE_SHIFT +: NIBBLE_W]),
        .zero   (item_reg.group_zero),
        .scale  (item_reg.group_scale),
        .act    (item_reg.act_high),
        .prod   (prod_hi),
        .deq    (deq_hi)
    );

    i4dq_acc #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_acc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (acc_ctrl),
        .prod_lo   (prod_lo),
        .prod_hi   (prod_hi),
        .acc_value (acc_value)
    );

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next  = state_reg;
        item_ready  = 1'b0;
        lane_ctrl   = '0;
        acc_ctrl    = '0;
        load        = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    state_next = ST_DEQ;
                end
            end
            ST_DEQ:
            begin
                lane_ctrl.dq_en = 1'b1;
                state_next      = ST_MUL;
            end
            ST_MUL:
            begin
                lane_ctrl.mul_en = 1'b1;
                state_next       = (mode_reg == MODE_DEQUANT) ? ST_EMIT_LO : ST_ADD_LO;
            end
            ST_ADD_LO:
            begin
                acc_ctrl.add_en = 1'b1;
                state_next      = ST_ADD_HI;
            end
            ST_ADD_HI:
            begin
                acc_ctrl.add_en = 1'b1;
                acc_ctrl.use_hi = 1'b1;
                state_next      = item_reg.vector_last ? ST_EMIT_DOT : ST_IDLE;
            end
            ST_EMIT_DOT:
            begin
                if (out_free)
                begin
                    load                   = 1'b1;
                    acc_ctrl.clear         = 1'b1;
                    result_next.value      = acc_value;
                    result_next.run_last   = 1'b1;
                    result_next.vector_end = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            ST_EMIT_LO:
            begin
                if (out_free)
                begin
                    load                   = 1'b1;
                    result_next.value      = {{(VALUE_W-DEQ_W){deq_lo[DEQ_W-1]}}, deq_lo};
                    result_next.run_last   = 1'b0;
                    result_next.vector_end = item_reg.vector_last;
                    state_next             = ST_EMIT_HI;
                end
            end
            ST_EMIT_HI:
            begin
                if (out_free)
                begin
                    load                   = 1'b1;
                    result_next.value      = {{(VALUE_W-DEQ_W){deq_hi[DEQ_W-1]}}, deq_hi};
                    result_next.run_last   = 1'b1;
                    result_next.vector_end = item_reg.vector_last;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mode_reg         <= MODE_DOT;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_DOT && out_free) |=> (acc_value == '0))
        else $error("accumulator not cleared after dot result");

    a_pair_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_HI && out_free) |=> (result_valid && result.run_last))
        else $error("second dequant word missing run_last");

    a_add_dot_only: assert property (@(posedge clk) disable iff (!rst_n)
        acc_ctrl.add_en |-> (mode_reg == MODE_DOT && !load))
        else $error("accumulator add outside dot mode");

endmodule

`default_nettype wire

@@ src/i4dq_lane.sv @@
`default_nettype none

module i4dq_lane
    import i4dq_pkg::*;
(
    input  wire logic                       clk,
    input  wire lane_ctrl_t                 ctrl,
    input  wire logic        [NIBBLE_W-1:0] nibble,
    input  wire logic        [ZERO_W-1:0]   zero,
    input  wire logic signed [SCALE_W-1:0]  scale,
    input  wire logic signed [ACT_W-1:0]    act,
    output logic signed      [PROD_W-1:0]   prod,
    output logic signed      [DEQ_W-1:0]    deq
);

    logic signed [DIFF_W-1:0] diff;
    logic signed [DQ_W-1:0]   dq_reg;
    logic signed [DQ_W-1:0]   dq_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign diff      = $signed({{(DIFF_W-NIBBLE_W){1'b0}}, nibble & NIBBLE_MASK})
                     - $signed({1'b0, zero});
    assign dq_next   = scale * diff;
    assign prod_next = act * dq_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.dq_en)
        begin
            dq_reg <= dq_next;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // saturate to q3.12
    always_comb
    begin
        if (dq_reg[DQ_W-1:DEQ_W-1] == {(DQ_W-DEQ_W+1){dq_reg[DQ_W-1]}})
        begin
            deq = dq_reg[DEQ_W-1:0];
        end
        else
        begin
            deq = {dq_reg[DQ_W-1], {(DEQ_W-1){~dq_reg[DQ_W-1]}}};
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ src/i4dq_acc.sv @@
`default_nettype none

module i4dq_acc
    import i4dq_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire acc_ctrl_t                 ctrl,
    input  wire logic signed [PROD_W-1:0]  prod_lo,
    input  wire logic signed [PROD_W-1:0]  prod_hi,
    output logic signed      [VALUE_W-1:0] acc_value
);

    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic signed [PROD_W-1:0]    prod;
    logic signed [ACC_WIDTH:0]   sum;

    assign prod = ctrl.use_hi ? prod_hi : prod_lo;
    assign sum  = (ACC_WIDTH+1)'(acc_reg) + (ACC_WIDTH+1)'(prod);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.add_en)
        begin
            if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
            begin
                acc_next = {sum[ACC_WIDTH], {(ACC_WIDTH-1){~sum[ACC_WIDTH]}}};
            end
            else
            begin
                acc_next = sum[ACC_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    generate
        if (ACC_WIDTH > VALUE_W)
        begin : g_clamp
            always_comb
            begin
                if (acc_reg[ACC_WIDTH-1:VALUE_W-1]
                    == {(ACC_WIDTH-VALUE_W+1){acc_reg[ACC_WIDTH-1]}})
                begin
                    acc_value = acc_reg[VALUE_W-1:0];
                end
                else
                begin
                    acc_value = {acc_reg[ACC_WIDTH-1], {(VALUE_W-1){~acc_reg[ACC_WIDTH-1]}}};
                end
            end
        end
        else if (ACC_WIDTH < VALUE_W)
        begin : g_extend
            assign acc_value = {{(VALUE_W-ACC_WIDTH){acc_reg[ACC_WIDTH-1]}}, acc_reg};
        end
        else
        begin : g_same
            assign acc_value = acc_reg[VALUE_W-1:0];
        end
    endgenerate

endmodule

`default_nettype wire
